>>> src/cwsk_pkg.sv
// Package for the time-of-day clock: command codes, state limits and reset values.
`default_nettype none
package cwsk_pkg;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_MIN_UP   = 3'd1,
		CMD_MIN_DOWN = 3'd2,
		CMD_MODE     = 3'd3,
		CMD_TEMP     = 3'd4
	} cmd_t;

	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HR_W   = 5;
	localparam int TEMP_W = 8;
	localparam int DIG_W  = 4;
	localparam int RAW_W  = 16;

	localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
	localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
	localparam logic [HR_W-1:0]   HR_LAST   = 5'd23;

	localparam logic [SEC_W-1:0]  SEC_RST   = 6'd0;
	localparam logic [MIN_W-1:0]  MIN_RST   = 6'd2;
	localparam logic [HR_W-1:0]   HR_RST    = 5'd5;
	localparam logic [TEMP_W-1:0] TEMP_RST  = 8'd23;

endpackage
`default_nettype wire

>>> src/cwsk_bcd.sv
// Splits an 8-bit value into its decimal tens (mod 10) and units digits.
`default_nettype none
module cwsk_bcd (
	input  wire logic [cwsk_pkg::TEMP_W-1:0] value,
	output logic      [cwsk_pkg::DIG_W-1:0]  tens,
	output logic      [cwsk_pkg::DIG_W-1:0]  units
);
	logic [15:0] prod;
	logic [4:0]  quot;
	logic [7:0]  rem;

	always_comb begin
		// value / 10 via reciprocal multiply, exact for all 8-bit inputs
		prod  = 16'(value) * 16'd205;
		quot  = prod[15:11];
		rem   = value - (8'(quot) * 8'd10);
		units = rem[3:0];
		if (quot >= 5'd20) begin
			tens = 4'(quot - 5'd20);
		end else if (quot >= 5'd10) begin
			tens = 4'(quot - 5'd10);
		end else begin
			tens = quot[3:0];
		end
	end
endmodule
`default_nettype wire

>>> src/clock_with_set_keys_and_temp_view.sv
// Top level of the time-of-day clock with minute keys and temperature view.
// One transaction per cycle is accepted. Each transaction is captured in an input
// register and applied to the clock state when it leaves that register; a tick
// loads the four display digits into the output register at the same edge as its
// state update, so a result is presented once its tick leaves the input register.
// Non-tick commands may update state and give no result. The only stall comes from
// a tick whose result cannot leave while out_ready low holds the output register.
`default_nettype none
module clock_with_set_keys_and_temp_view (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [2:0]                    cmd,
	input  wire logic [cwsk_pkg::RAW_W-1:0]    temp_raw,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [cwsk_pkg::DIG_W-1:0]    digit_left,
	output logic      [cwsk_pkg::DIG_W-1:0]    digit_second,
	output logic      [cwsk_pkg::DIG_W-1:0]    digit_third,
	output logic      [cwsk_pkg::DIG_W-1:0]    digit_right,
	output logic                               shows_temp
);
	logic                          valid_s1;
	cwsk_pkg::cmd_t                cmd_s1;
	logic [cwsk_pkg::RAW_W-1:0]    temp_raw_s1;

	logic [cwsk_pkg::SEC_W-1:0]    sec_q, sec_d;
	logic [cwsk_pkg::MIN_W-1:0]    min_q, min_d;
	logic [cwsk_pkg::HR_W-1:0]     hr_q, hr_d;
	logic                          mode_q, mode_d;
	logic [cwsk_pkg::TEMP_W-1:0]   temp_q, temp_d;

	logic [cwsk_pkg::MIN_W-1:0]    up_min, dn_min;
	logic [cwsk_pkg::HR_W-1:0]     up_hr, dn_hr;

	logic                          is_tick, out_free, advance;
	logic [cwsk_pkg::TEMP_W-1:0]   left_src;
	logic [cwsk_pkg::DIG_W-1:0]    left_tens, left_units, min_tens, min_units;

	logic                          out_valid_q;
	logic [cwsk_pkg::DIG_W-1:0]    dig_left_q, dig_second_q, dig_third_q, dig_right_q;
	logic                          shows_temp_q;

	assign is_tick  = valid_s1 && (cmd_s1 == cwsk_pkg::CMD_TICK);
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!is_tick || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1      <= cwsk_pkg::cmd_t'(cmd);
			temp_raw_s1 <= temp_raw;
		end
	end

	always_comb begin
		if (min_q >= cwsk_pkg::MIN_LAST) begin
			up_min = '0;
			up_hr  = (hr_q >= cwsk_pkg::HR_LAST) ? '0 : hr_q + 1'b1;
		end else begin
			up_min = min_q + 1'b1;
			up_hr  = hr_q;
		end
		if (min_q == '0 || min_q > cwsk_pkg::MIN_LAST) begin
			dn_min = cwsk_pkg::MIN_LAST;
			dn_hr  = (hr_q == '0 || hr_q > cwsk_pkg::HR_LAST) ? cwsk_pkg::HR_LAST
				: hr_q - 1'b1;
		end else begin
			dn_min = min_q - 1'b1;
			dn_hr  = hr_q;
		end
	end

	always_comb begin
		sec_d  = sec_q;
		min_d  = min_q;
		hr_d   = hr_q;
		mode_d = mode_q;
		temp_d = temp_q;
		if (advance) begin
			case (cmd_s1)
				cwsk_pkg::CMD_TICK: begin
					if (sec_q >= cwsk_pkg::SEC_LAST) begin
						sec_d = '0;
						min_d = up_min;
						hr_d  = up_hr;
					end else begin
						sec_d = sec_q + 1'b1;
					end
				end
				cwsk_pkg::CMD_MIN_UP: begin
					if (!mode_q) begin
						min_d = up_min;
						hr_d  = up_hr;
					end
				end
				cwsk_pkg::CMD_MIN_DOWN: begin
					if (!mode_q) begin
						min_d = dn_min;
						hr_d  = dn_hr;
					end
				end
				cwsk_pkg::CMD_MODE: begin
					mode_d = !mode_q;
				end
				cwsk_pkg::CMD_TEMP: begin
					if (temp_raw_s1 != '0) begin
						temp_d = temp_raw_s1[cwsk_pkg::RAW_W-1 -: cwsk_pkg::TEMP_W];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= cwsk_pkg::SEC_RST;
			min_q  <= cwsk_pkg::MIN_RST;
			hr_q   <= cwsk_pkg::HR_RST;
			mode_q <= 1'b0;
			temp_q <= cwsk_pkg::TEMP_RST;
		end else begin
			sec_q  <= sec_d;
			min_q  <= min_d;
			hr_q   <= hr_d;
			mode_q <= mode_d;
			temp_q <= temp_d;
		end
	end

	assign left_src = mode_q ? temp_q : cwsk_pkg::TEMP_W'(hr_d);

	cwsk_bcd u_bcd_left (
		.value (left_src),
		.tens  (left_tens),
		.units (left_units)
	);

	cwsk_bcd u_bcd_min (
		.value (cwsk_pkg::TEMP_W'(min_d)),
		.tens  (min_tens),
		.units (min_units)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && is_tick) begin
			dig_left_q   <= left_tens;
			dig_third_q  <= left_units;
			dig_second_q <= mode_q ? '0 : min_tens;
			dig_right_q  <= mode_q ? '0 : min_units;
			shows_temp_q <= mode_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_left   = dig_left_q;
	assign digit_second = dig_second_q;
	assign digit_third  = dig_third_q;
	assign digit_right  = dig_right_q;
	assign shows_temp   = shows_temp_q;
endmodule
`default_nettype wire
